// ===== hdl/tcw_pkg.sv =====
package tcw_pkg;

  // Screen geometry
  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;

  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int CELL_W = 11;
  localparam int CHAR_W = 8;

  // Control bytes
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CH_ESCAPE    = 8'h1B;
  localparam logic [CHAR_W-1:0] CH_FORMFEED  = 8'h0C;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
  localparam logic [CHAR_W-1:0] CLEAR_ATTR   = 8'd15;

  typedef enum logic [1:0] {
    ACT_NONE      = 2'd0,
    ACT_WRITE     = 2'd1,
    ACT_CHAR_ONLY = 2'd2,
    ACT_CLEAR     = 2'd3
  } action_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_WIN_LEFT   = 2'd0,
    REG_WIN_RIGHT  = 2'd1,
    REG_WIN_TOP    = 2'd2,
    REG_WIN_BOTTOM = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [COL_W-1:0] left;
    logic [COL_W-1:0] right;
    logic [ROW_W-1:0] top;
    logic [ROW_W-1:0] bottom;
  } win_t;

  typedef struct packed {
    action_t           action;
    logic [CELL_W-1:0] cell_idx;
    logic [CHAR_W-1:0] char_out;
    logic [CHAR_W-1:0] attr_out;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic              armed;
  } step_res_t;

  // row * COLUMNS + col, wrapped to the cell index width
  function automatic logic [CELL_W-1:0] cell_of(input logic [COL_W-1:0] col,
                                                input logic [ROW_W-1:0] row);
    logic [CELL_W:0] prod;
    prod = (CELL_W+1)'(row) * (CELL_W+1)'(COLUMNS) + (CELL_W+1)'(col);
    return prod[CELL_W-1:0];
  endfunction

endpackage

// ===== hdl/text_console_cursor_writer_core.sv =====
// Text console cursor writer. Each input transfer carries one character byte
// and one attribute byte; each produces exactly one result transfer telling the
// screen memory what to do (nothing, write char+attribute, write char only, or
// clear the window) at which cell, plus the cursor position afterwards. The
// cursor stays inside a window set through the cfg_ port (left/right columns,
// top/bottom rows; right and bottom are exclusive). Newline goes to the left
// edge of the next row, backspace steps back and blanks, ESC then form feed
// clears the window and homes the cursor. Throughput is one character per
// clock unless out_ready holds back the result register: the input register
// feeds a single pass of compare/increment logic and a constant-multiply cell
// address into the result register, and the cursor registers update in that
// same cycle. A character passes the input register, then the result register.
// Window registers may only be written while the block is idle.
module text_console_cursor_writer_core (
  input  logic                       clk,
  input  logic                       rst_n,
  // character input
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [tcw_pkg::CHAR_W-1:0] in_char_code,
  input  logic [tcw_pkg::CHAR_W-1:0] in_color,
  // result output
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [1:0]                 out_action,
  output logic [tcw_pkg::CELL_W-1:0] out_cell_res,
  output logic [tcw_pkg::CHAR_W-1:0] out_char_out,
  output logic [tcw_pkg::CHAR_W-1:0] out_attr_out,
  output logic [tcw_pkg::COL_W-1:0]  out_cursor_col,
  output logic [tcw_pkg::ROW_W-1:0]  out_cursor_row,
  // configuration writes
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [1:0]                 cfg_index,
  input  logic [tcw_pkg::COL_W-1:0]  cfg_data
);
  import tcw_pkg::*;

  // Window registers
  win_t win_r;

  // Cursor state
  logic [COL_W-1:0] cur_col_r;
  logic [ROW_W-1:0] cur_row_r;
  logic             armed_r;

  // Input stage
  logic              s1_valid_r;
  logic [CHAR_W-1:0] s1_char_r;
  logic [CHAR_W-1:0] s1_color_r;

  // Result stage
  logic      out_valid_r;
  step_res_t res_r;
  step_res_t res_nxt;

  logic s2_ready;
  logic s1_fire;

  assign cfg_ready = 1'b1;

  // Result register frees up when empty or being drained this cycle
  assign s2_ready = !out_valid_r || out_ready;
  assign s1_fire  = s1_valid_r && s2_ready;
  assign in_ready = !s1_valid_r || s2_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r.left   <= '0;
      win_r.right  <= COL_W'(COLUMNS);
      win_r.top    <= '0;
      win_r.bottom <= ROW_W'(ROWS);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_WIN_LEFT:   win_r.left   <= cfg_data;
        REG_WIN_RIGHT:  win_r.right  <= cfg_data;
        REG_WIN_TOP:    win_r.top    <= cfg_data[ROW_W-1:0];
        REG_WIN_BOTTOM: win_r.bottom <= cfg_data[ROW_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_char_r  <= in_char_code;
      s1_color_r <= in_color;
    end
  end

  tcw_step u_step (
    .cur_col   (cur_col_r),
    .cur_row   (cur_row_r),
    .armed     (armed_r),
    .win       (win_r),
    .char_code (s1_char_r),
    .color     (s1_color_r),
    .res       (res_nxt)
  );

  // Cursor state advances with each character moved into the result stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_col_r <= '0;
      cur_row_r <= '0;
      armed_r   <= 1'b0;
    end else if (s1_fire) begin
      cur_col_r <= res_nxt.col;
      cur_row_r <= res_nxt.row;
      armed_r   <= res_nxt.armed;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_ready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_action     = res_r.action;
  assign out_cell_res   = res_r.cell_idx;
  assign out_char_out   = res_r.char_out;
  assign out_attr_out   = res_r.attr_out;
  assign out_cursor_col = res_r.col;
  assign out_cursor_row = res_r.row;

endmodule

// ===== hdl/tcw_step.sv =====
// Next-cursor and screen-write decode for one character.
module tcw_step (
  input  logic [tcw_pkg::COL_W-1:0]  cur_col,
  input  logic [tcw_pkg::ROW_W-1:0]  cur_row,
  input  logic                       armed,
  input  tcw_pkg::win_t              win,
  input  logic [tcw_pkg::CHAR_W-1:0] char_code,
  input  logic [tcw_pkg::CHAR_W-1:0] color,
  output tcw_pkg::step_res_t         res
);
  import tcw_pkg::*;

  logic [COL_W-1:0] n_col;
  logic [ROW_W-1:0] n_row;
  logic [ROW_W:0]   row6;
  logic [ROW_W:0]   nl_row;
  logic [COL_W:0]   col_inc;

  // Pull the cursor back into the window before using it
  always_comb begin
    if (cur_col >= win.right) begin
      n_col = win.left;
      row6  = {1'b0, cur_row} + 1'b1;
    end else begin
      n_col = cur_col;
      row6  = {1'b0, cur_row};
    end
    n_row = (row6 >= {1'b0, win.bottom}) ? win.top : row6[ROW_W-1:0];
  end

  assign nl_row  = {1'b0, n_row} + 1'b1;
  assign col_inc = {1'b0, n_col} + 1'b1;

  always_comb begin
    res          = '0;
    res.action   = ACT_NONE;
    res.col      = n_col;
    res.row      = n_row;
    res.armed    = 1'b0;
    if (armed && char_code == CH_FORMFEED) begin
      res.col      = win.left;
      res.row      = win.top;
      res.action   = ACT_CLEAR;
      res.cell_idx = cell_of(win.left, win.top);
      res.char_out = CH_SPACE;
      res.attr_out = CLEAR_ATTR;
    end else if (char_code == CH_NEWLINE) begin
      res.col = win.left;
      res.row = (nl_row >= {1'b0, win.bottom}) ? win.top : nl_row[ROW_W-1:0];
    end else if (char_code == CH_BACKSPACE) begin
      if (n_col != '0 || n_row != '0) begin
        if (n_col > win.left) begin
          res.col = n_col - 1'b1;
        end else begin
          res.col = (win.right != '0) ? win.right - 1'b1 : '0;
          if (n_row > win.top) begin
            res.row = n_row - 1'b1;
          end
        end
      end
      res.action   = ACT_CHAR_ONLY;
      res.cell_idx = cell_of(res.col, res.row);
      res.char_out = CH_SPACE;
    end else if (char_code == CH_ESCAPE) begin
      res.armed = 1'b1;
    end else begin
      res.action   = ACT_WRITE;
      res.cell_idx = cell_of(n_col, n_row);
      res.char_out = char_code;
      res.attr_out = color;
      if (col_inc >= {1'b0, win.right}) begin
        res.col = win.left;
        res.row = (nl_row >= {1'b0, win.bottom}) ? win.top : nl_row[ROW_W-1:0];
      end else begin
        res.col = col_inc[COL_W-1:0];
      end
    end
  end

endmodule

// ===== hdl/tcw_checker.sv =====
module tcw_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [1:0]                 out_action,
  input logic [tcw_pkg::CELL_W-1:0] out_cell_res,
  input logic [tcw_pkg::CHAR_W-1:0] out_char_out,
  input logic [tcw_pkg::CHAR_W-1:0] out_attr_out
);
  import tcw_pkg::*;

  // No-op results carry zeroed write fields
  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_action == ACT_NONE |->
      out_cell_res == '0 && out_char_out == '0 && out_attr_out == '0)
    else $error("no-op result with nonzero write fields");

  // Window clear writes blank cells in the default attribute
  a_clear_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_action == ACT_CLEAR |->
      out_char_out == CH_SPACE && out_attr_out == CLEAR_ATTR)
    else $error("clear with wrong fill");

  // Backspace blanks only the char byte
  a_bs_blank: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_action == ACT_CHAR_ONLY |->
      out_char_out == CH_SPACE && out_attr_out == '0)
    else $error("backspace with wrong blank");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable(out_action) && $stable(out_cell_res))
    else $error("result changed while stalled");

endmodule

bind text_console_cursor_writer_core tcw_checker u_tcw_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_action   (out_action),
  .out_cell_res (out_cell_res),
  .out_char_out (out_char_out),
  .out_attr_out (out_attr_out)
);

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import tcw_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 400;
  // settling margin after the last result, before the window is rewritten
  localparam int SETTLE_CYCLES = 4;

  // one character transfer as offered on the input channel
  typedef struct {
    logic [CHAR_W-1:0] code;
    logic [CHAR_W-1:0] color;
  } char_item_t;

  // what the screen memory is told for one character
  typedef struct {
    action_t           act;
    logic [CELL_W-1:0] cell_idx;
    logic [CHAR_W-1:0] glyph;
    logic [CHAR_W-1:0] attr;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
  } screen_op_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [CHAR_W-1:0] in_char_code = '0;
  logic [CHAR_W-1:0] in_color = '0;

  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [1:0]        out_action;
  logic [CELL_W-1:0] out_cell_res;
  logic [CHAR_W-1:0] out_char_out;
  logic [CHAR_W-1:0] out_attr_out;
  logic [COL_W-1:0]  out_cursor_col;
  logic [ROW_W-1:0]  out_cursor_row;

  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [1:0]        cfg_index = REG_WIN_LEFT;
  logic [COL_W-1:0]  cfg_data = '0;

  text_console_cursor_writer_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_char_code   (in_char_code),
    .in_color       (in_color),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_action     (out_action),
    .out_cell_res   (out_cell_res),
    .out_char_out   (out_char_out),
    .out_attr_out   (out_attr_out),
    .out_cursor_col (out_cursor_col),
    .out_cursor_row (out_cursor_row),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #4 clk = ~clk;

  // --------------------------------------------------------------------------
  // Shared testbench state
  // --------------------------------------------------------------------------
  char_item_t char_backlog[$];       // characters not yet offered
  screen_op_t pending_screen_ops[$]; // predicted results, oldest first

  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;

  // idle rates in percent, changed per phase (at the falling edge)
  int unsigned tx_idle_pct = 0;
  int unsigned rx_stall_pct = 0;

  // long receiver hold-off: the sequencer bumps hold_requests, the hold
  // process serves each request with HOLD_CYCLES of out_ready low
  int unsigned hold_requests = 0;
  int unsigned hold_served = 0;
  int unsigned hold_left = 0;

  // cursor model state and its copy of the window registers
  win_t             win_q = '{left: 7'd0, right: 7'd80, top: 5'd0, bottom: 5'd25};
  logic [COL_W-1:0] cur_col_q = '0;
  logic [ROW_W-1:0] cur_row_q = '0;
  bit               esc_seen_q = 1'b0;

  // --------------------------------------------------------------------------
  // Cursor predictor
  // --------------------------------------------------------------------------
  function automatic logic [CELL_W-1:0] cell_addr(input int col, input int row);
    return CELL_W'(row * COLUMNS + col);
  endfunction

  // Applies one character to the cursor model and returns the expected result.
  // Works in plain ints so intermediate row/col overflow behaves like the
  // unbounded arithmetic; state is trimmed to register widths at the end.
  function automatic screen_op_t next_screen_op(input logic [CHAR_W-1:0] code,
                                                input logic [CHAR_W-1:0] color);
    int col;
    int row;
    int wl;
    int wr;
    int wt;
    int wb;
    bit armed;
    screen_op_t op;
    col   = cur_col_q;
    row   = cur_row_q;
    wl    = win_q.left;
    wr    = win_q.right;
    wt    = win_q.top;
    wb    = win_q.bottom;
    armed = esc_seen_q;
    op.act      = ACT_NONE;
    op.cell_idx = '0;
    op.glyph    = '0;
    op.attr     = '0;

    // pull a stale cursor back inside the window first
    if (col >= wr) begin
      col = wl;
      row = row + 1;
    end
    if (row >= wb) row = wt;

    esc_seen_q = 1'b0;

    if (armed && code == CH_FORMFEED) begin
      // escape + form feed: clear window, cursor home
      col = wl;
      row = wt;
      op.act      = ACT_CLEAR;
      op.cell_idx = cell_addr(col, row);
      op.glyph    = CH_SPACE;
      op.attr     = CLEAR_ATTR;
    end else if (code == CH_NEWLINE) begin
      col = wl;
      row = row + 1;
      if (row >= wb) row = wt;
    end else if (code == CH_BACKSPACE) begin
      // nothing moves at screen cell 0
      if (col != 0 || row != 0) begin
        if (col > wl) begin
          col = col - 1;
        end else begin
          col = (wr > 0) ? wr - 1 : 0;
          if (row > wt) row = row - 1;
        end
      end
      op.act      = ACT_CHAR_ONLY;
      op.cell_idx = cell_addr(col, row);
      op.glyph    = CH_SPACE;
    end else if (code == CH_ESCAPE) begin
      esc_seen_q = 1'b1;
    end else begin
      // printable, a lone form feed included
      op.act      = ACT_WRITE;
      op.cell_idx = cell_addr(col, row);
      op.glyph    = code;
      op.attr     = color;
      col = col + 1;
      if (col >= wr) begin
        col = wl;
        row = row + 1;
        if (row >= wb) row = wt;
      end
    end

    cur_col_q = COL_W'(col);
    cur_row_q = ROW_W'(row);
    op.col = cur_col_q;
    op.row = cur_row_q;
    return op;
  endfunction

  // --------------------------------------------------------------------------
  // Driver: offers characters from the backlog, predicts on each transfer
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : driver
    char_item_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        pending_screen_ops.push_back(next_screen_op(in_char_code, in_color));
      end
      // valid stays up with a stable payload until the transfer happens
      if (!in_valid || in_ready) begin
        if (char_backlog.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
          nxt = char_backlog.pop_front();
          in_valid     <= 1'b1;
          in_char_code <= nxt.code;
          in_color     <= nxt.color;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver hold-off counter
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : hold_counter
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_requests) begin
      hold_served <= hold_served + 1;
      hold_left   <= HOLD_CYCLES;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: checks every result transfer against the oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    screen_op_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_screen_ops.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result: act %0d cell %0d ch %h attr %h col %0d row %0d",
                     out_action, out_cell_res, out_char_out, out_attr_out,
                     out_cursor_col, out_cursor_row);
        end else begin
          want = pending_screen_ops.pop_front();
          if (out_action !== want.act || out_cell_res !== want.cell_idx ||
              out_char_out !== want.glyph || out_attr_out !== want.attr ||
              out_cursor_col !== want.col || out_cursor_row !== want.row) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: exp act %0d cell %0d ch %h attr %h col %0d row %0d",
                       want.act, want.cell_idx, want.glyph, want.attr,
                       want.col, want.row,
                       " | got act %0d cell %0d ch %h attr %h col %0d row %0d",
                       out_action, out_cell_res, out_char_out, out_attr_out,
                       out_cursor_col, out_cursor_row);
          end
        end
      end
      out_ready <= (hold_left == 0) && ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic void push_char(input logic [CHAR_W-1:0] code,
                                    input logic [CHAR_W-1:0] color);
    char_item_t it;
    it.code  = code;
    it.color = color;
    char_backlog.push_back(it);
  endfunction

  function automatic logic [CHAR_W-1:0] any_byte();
    return CHAR_W'($urandom_range(0, 255));
  endfunction

  // Mostly text with line breaks and corrections; escape is usually followed
  // by form feed, sometimes by some other byte.
  function automatic void queue_text(input int n);
    int emitted;
    int pick;
    emitted = 0;
    while (emitted < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        push_char(any_byte(), any_byte());
      end else if (pick < 72) begin
        push_char(CH_NEWLINE, any_byte());
      end else if (pick < 84) begin
        push_char(CH_BACKSPACE, any_byte());
      end else if (pick < 94) begin
        push_char(CH_ESCAPE, any_byte());
        emitted++;
        if ($urandom_range(0, 3) != 0) push_char(CH_FORMFEED, any_byte());
        else push_char(any_byte(), any_byte());
      end else begin
        push_char(CH_FORMFEED, any_byte());
      end
      emitted++;
    end
  endfunction

  // Narrow windows so wraps at both edges come often.
  function automatic win_t random_window();
    int l;
    int t;
    win_t w;
    l = $urandom_range(0, 78);
    t = $urandom_range(0, 23);
    w.left   = COL_W'(l);
    w.right  = COL_W'($urandom_range(l + 1, (l + 12 > 80) ? 80 : l + 12));
    w.top    = ROW_W'(t);
    w.bottom = ROW_W'($urandom_range(t + 1, (t + 5 > 25) ? 25 : t + 5));
    return w;
  endfunction

  // Sender pause: wait until every offered character has its result back,
  // then wait out the settling margin. Sampled at the falling edge, returns there.
  task automatic wait_idle();
    do @(negedge clk);
    while (char_backlog.size() != 0 || in_valid || pending_screen_ops.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Writes all four window registers back to back, valid held high between
  // transfers; the model copy follows each transfer.
  task automatic program_window(input win_t w);
    logic [COL_W-1:0] vals [4];
    cfg_reg_t         regs [4];
    vals = '{w.left, w.right, COL_W'(w.top), COL_W'(w.bottom)};
    regs = '{REG_WIN_LEFT, REG_WIN_RIGHT, REG_WIN_TOP, REG_WIN_BOTTOM};
    @(posedge clk);
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= regs[i];
      cfg_data  <= vals[i];
      do @(posedge clk);
      while (!cfg_ready);
      case (regs[i])
        REG_WIN_LEFT:   win_q.left   = vals[i];
        REG_WIN_RIGHT:  win_q.right  = vals[i];
        REG_WIN_TOP:    win_q.top    = vals[i][ROW_W-1:0];
        REG_WIN_BOTTOM: win_q.bottom = vals[i][ROW_W-1:0];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  // One random phase: new window while idle, idle rates, then text.
  task automatic text_phase(input win_t w, input int tx, input int rx, input int n,
                            input bit hold);
    wait_idle();
    program_window(w);
    @(negedge clk);
    tx_idle_pct  = tx;
    rx_stall_pct = rx;
    queue_text(n);
    if (hold) hold_requests++;
  endtask

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  initial begin : sequencer
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed, reset window (full screen), cursor at cell 0
    @(negedge clk);
    push_char(CH_BACKSPACE, 8'h77);   // backspace at screen cell 0: no move
    push_char(8'h00, 8'hFF);          // field extremes
    push_char(8'hFF, 8'h00);
    push_char(CH_NEWLINE, 8'h00);
    push_char(CH_BACKSPACE, 8'h00);   // from left edge: up a row, to right-1
    push_char(8'h5A, 8'h55);          // last column: wraps to next row
    push_char(CH_FORMFEED, 8'h1E);    // lone form feed prints
    push_char(CH_ESCAPE, 8'hAA);      // escape + form feed clears
    push_char(CH_FORMFEED, 8'hAA);
    push_char(CH_ESCAPE, 8'h01);      // escape + ordinary byte prints it
    push_char(8'h41, 8'h07);
    push_char(CH_ESCAPE, 8'h01);      // escape twice stays armed
    push_char(CH_ESCAPE, 8'h01);
    push_char(CH_FORMFEED, 8'h01);
    push_char(CH_ESCAPE, 8'h02);      // escape + newline is a plain newline
    push_char(CH_NEWLINE, 8'h02);
    push_char(CH_ESCAPE, 8'h03);      // escape + backspace is a plain backspace
    push_char(CH_BACKSPACE, 8'h03);

    // Directed, tiny window: right and bottom wraps, backspace at window corner
    wait_idle();
    program_window('{left: 7'd2, right: 7'd5, top: 5'd1, bottom: 5'd3});
    @(negedge clk);
    for (int i = 0; i < 7; i++) push_char(8'h61 + CHAR_W'(i), 8'h80 | CHAR_W'(i));
    push_char(CH_NEWLINE, 8'h00);
    push_char(CH_BACKSPACE, 8'h00);

    // Random phases: window extremes, an inconsistent window, idle mixes
    text_phase('{left: 7'd0, right: 7'd80, top: 5'd0, bottom: 5'd25}, 0, 0, 200, 1'b0);
    text_phase('{left: 7'd0, right: 7'd1, top: 5'd0, bottom: 5'd1}, 67, 0, 120, 1'b0);
    text_phase('{left: 7'd79, right: 7'd80, top: 5'd24, bottom: 5'd25}, 0, 67, 150, 1'b0);
    text_phase(random_window(), 31, 31, 200, 1'b0);
    text_phase('{left: 7'd79, right: 7'd1, top: 5'd24, bottom: 5'd1}, 0, 0, 100, 1'b0);
    // receiver held off while the sender keeps offering: block backs up
    text_phase(random_window(), 0, 0, 200, 1'b1);
    text_phase(random_window(), 31, 31, 230, 1'b0);

    wait_idle();
    if (fail_count == 0 && pending_screen_ops.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
